// ----- sv/mdu_pkg.sv -----
// ---------------------------------------------------------------------------
// mdu_pkg: shared types and codes for the RV64M multiply/divide unit
// Operation codes, decoded operation record and width constants.
// ---------------------------------------------------------------------------
`default_nettype none

package mdu_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned TAG_W     = 5;
  localparam int unsigned ACT_W     = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_MUL    = 4'd0,
    ACT_MULH   = 4'd1,
    ACT_MULHSU = 4'd2,
    ACT_MULHU  = 4'd3,
    ACT_DIV    = 4'd4,
    ACT_DIVU   = 4'd5,
    ACT_REM    = 4'd6,
    ACT_REMU   = 4'd7,
    ACT_MULW   = 4'd8,
    ACT_DIVW   = 4'd9,
    ACT_DIVUW  = 4'd10,
    ACT_REMW   = 4'd11,
    ACT_REMUW  = 4'd12
  } action_e;

  // Classified operation handed from front to back end.
  typedef struct packed {
    logic             legal;   // known action code
    logic             is_div;
    logic             word;    // 32-bit form, sign-extend result
    logic             sel_hi;  // multiply: high half, divide: remainder
    logic             sgn_a;
    logic             sgn_b;
    logic [XLEN-1:0]  a;       // word forms already extended to XLEN
    logic [XLEN-1:0]  b;
    logic [TAG_W-1:0] tag;
  } mdu_op_t;

  function automatic logic [XLEN-1:0] sext_word(input logic [XLEN-1:0] v);
    sext_word = {{(XLEN/2){v[XLEN/2-1]}}, v[XLEN/2-1:0]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/mdu_if.sv -----
// ---------------------------------------------------------------------------
// mdu_req_if / mdu_rsp_if: valid/ready channels of the multiply/divide unit
// Request carries action, operands and tag; response carries value and tag.
// ---------------------------------------------------------------------------
`default_nettype none

interface mdu_req_if;
  logic                          valid;
  logic                          ready;
  logic [mdu_pkg::ACT_W-1:0]     action;
  logic [mdu_pkg::XLEN-1:0]      operand_a;
  logic [mdu_pkg::XLEN-1:0]      operand_b;
  logic [mdu_pkg::TAG_W-1:0]     dest_tag;

  modport source (output valid, action, operand_a, operand_b, dest_tag, input ready);
  modport sink   (input valid, action, operand_a, operand_b, dest_tag, output ready);
endinterface

interface mdu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mdu_pkg::XLEN-1:0]      result_value;
  logic [mdu_pkg::TAG_W-1:0]     result_tag;

  modport source (output valid, result_value, result_tag, input ready);
  modport sink   (input valid, result_value, result_tag, output ready);
endinterface

`default_nettype wire

// ----- sv/mdu_front.sv -----
// ---------------------------------------------------------------------------
// mdu_front: request decode and operation queue
// Classifies each request and buffers it for the execution back end.
// ---------------------------------------------------------------------------
`default_nettype none

module mdu_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  mdu_req_if.sink              req_i,
  output mdu_pkg::mdu_op_t     op_o,
  output logic                 op_valid_o,
  input  wire logic            op_pop_i
);

  mdu_pkg::mdu_op_t dec;
  mdu_pkg::mdu_op_t mem_q [mdu_pkg::QUEUE_DEPTH];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;
  logic [mdu_pkg::XLEN/2-1:0] a_lo, b_lo;

  assign a_lo = req_i.operand_a[mdu_pkg::XLEN/2-1:0];
  assign b_lo = req_i.operand_b[mdu_pkg::XLEN/2-1:0];

  always_comb begin
    dec        = '0;
    dec.legal  = 1'b1;
    dec.a      = req_i.operand_a;
    dec.b      = req_i.operand_b;
    dec.tag    = req_i.dest_tag;
    case (mdu_pkg::action_e'(req_i.action))
      mdu_pkg::ACT_MUL:    ;
      mdu_pkg::ACT_MULH:   begin dec.sel_hi = 1'b1; dec.sgn_a = 1'b1; dec.sgn_b = 1'b1; end
      mdu_pkg::ACT_MULHSU: begin dec.sel_hi = 1'b1; dec.sgn_a = 1'b1; end
      mdu_pkg::ACT_MULHU:  dec.sel_hi = 1'b1;
      mdu_pkg::ACT_DIV:    begin dec.is_div = 1'b1; dec.sgn_a = 1'b1; dec.sgn_b = 1'b1; end
      mdu_pkg::ACT_DIVU:   dec.is_div = 1'b1;
      mdu_pkg::ACT_REM:    begin
        dec.is_div = 1'b1; dec.sel_hi = 1'b1; dec.sgn_a = 1'b1; dec.sgn_b = 1'b1;
      end
      mdu_pkg::ACT_REMU:   begin dec.is_div = 1'b1; dec.sel_hi = 1'b1; end
      mdu_pkg::ACT_MULW:   dec.word = 1'b1;
      mdu_pkg::ACT_DIVW:   begin
        dec.is_div = 1'b1; dec.word = 1'b1; dec.sgn_a = 1'b1; dec.sgn_b = 1'b1;
      end
      mdu_pkg::ACT_DIVUW:  begin dec.is_div = 1'b1; dec.word = 1'b1; end
      mdu_pkg::ACT_REMW:   begin
        dec.is_div = 1'b1; dec.word = 1'b1; dec.sel_hi = 1'b1;
        dec.sgn_a = 1'b1; dec.sgn_b = 1'b1;
      end
      mdu_pkg::ACT_REMUW:  begin dec.is_div = 1'b1; dec.word = 1'b1; dec.sel_hi = 1'b1; end
      default:             dec.legal = 1'b0;
    endcase
    // word forms work on extended low halves
    if (dec.word) begin
      dec.a = dec.sgn_a ? mdu_pkg::sext_word(req_i.operand_a)
                        : {{(mdu_pkg::XLEN/2){1'b0}}, a_lo};
      dec.b = dec.sgn_b ? mdu_pkg::sext_word(req_i.operand_b)
                        : {{(mdu_pkg::XLEN/2){1'b0}}, b_lo};
    end
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign op_valid_o  = (cnt_q != 2'd0);
  assign pop         = op_pop_i && op_valid_o;
  assign op_o        = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- sv/mdu_back.sv -----
// ---------------------------------------------------------------------------
// mdu_back: multiply/divide execution back end
// Shared 32x32 multiplier over four steps, radix-2 restoring divider,
// sign fix-up and a registered result slot.
// ---------------------------------------------------------------------------
`default_nettype none

module mdu_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  mdu_pkg::mdu_op_t     op_i,
  input  wire logic            op_valid_i,
  output logic                 op_pop_o,
  mdu_rsp_if.source            rsp_o
);

  localparam int unsigned W = mdu_pkg::XLEN;
  localparam int unsigned H = W / 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIX  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [$clog2(W)-1:0] cnt_q;
  mdu_pkg::mdu_op_t    op_q;
  logic [W-1:0]        ma_q, mb_q;
  logic [2*W-1:0]      acc_q;
  logic                neg_q, zero_q;
  logic                out_valid_q;
  logic [W-1:0]        out_value_q;
  logic [mdu_pkg::TAG_W-1:0] out_tag_q;

  logic                na, nb, slot_free;
  logic [W-1:0]        ma, mb;
  logic [H-1:0]        pa, pb;
  logic [W-1:0]        pp;
  logic [2*W-1:0]      pp_sh;
  logic [2*W:0]        shifted;
  logic [W+1:0]        diff;
  logic                ge;
  logic [2*W-1:0]      prod;
  logic [W-1:0]        quo, rem, res;

  assign na = op_i.sgn_a && op_i.a[W-1];
  assign nb = op_i.sgn_b && op_i.b[W-1];
  assign ma = na ? (~op_i.a + 1'b1) : op_i.a;
  assign mb = nb ? (~op_i.b + 1'b1) : op_i.b;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign op_pop_o  = (state_q == ST_IDLE) && op_valid_i;

  // one partial product per step
  assign pa = cnt_q[1] ? ma_q[W-1:H] : ma_q[H-1:0];
  assign pb = cnt_q[0] ? mb_q[W-1:H] : mb_q[H-1:0];
  assign pp = pa * pb;

  always_comb begin
    case ({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})
      2'd0:    pp_sh = {{W{1'b0}}, pp};
      2'd1:    pp_sh = {{H{1'b0}}, pp, {H{1'b0}}};
      default: pp_sh = {pp, {W{1'b0}}};
    endcase
  end

  // restoring divide step: acc = {remainder, dividend/quotient}
  assign shifted = {acc_q, 1'b0};
  assign diff    = {1'b0, shifted[2*W:W]} - {2'b00, mb_q};
  assign ge      = !diff[W+1];

  assign prod = neg_q ? (~acc_q + 1'b1) : acc_q;
  assign quo  = neg_q ? (~acc_q[W-1:0] + 1'b1) : acc_q[W-1:0];
  assign rem  = op_q.sgn_a && op_q.a[W-1] ? (~acc_q[2*W-1:W] + 1'b1) : acc_q[2*W-1:W];

  always_comb begin
    if (!op_q.legal) begin
      res = '0;
    end else if (!op_q.is_div) begin
      res = op_q.sel_hi ? prod[2*W-1:W] : prod[W-1:0];
    end else if (zero_q) begin
      res = op_q.sel_hi ? op_q.a : {W{1'b1}};
    end else begin
      res = op_q.sel_hi ? rem : quo;
    end
    if (op_q.word) res = mdu_pkg::sext_word(res);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (op_valid_i) begin
        if (!op_i.legal)      state_d = ST_FIX;
        else if (op_i.is_div) state_d = ST_DIV;
        else                  state_d = ST_MUL;
      end
      ST_MUL:  if (cnt_q == ($clog2(W))'(3)) state_d = ST_FIX;
      ST_DIV:  if (cnt_q == ($clog2(W))'(W - 1)) state_d = ST_FIX;
      ST_FIX:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE || state_d == ST_FIX) cnt_q <= '0;
      else                                         cnt_q <= cnt_q + 1'b1;
      if (state_q == ST_FIX && slot_free) out_valid_q <= 1'b1;
      else if (rsp_o.ready)               out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        op_q   <= op_i;
        ma_q   <= ma;
        mb_q   <= mb;
        neg_q  <= op_i.is_div ? (na ^ nb) : (na ^ nb);
        zero_q <= (op_i.b == '0);
        acc_q  <= op_i.is_div ? {{W{1'b0}}, ma} : '0;
      end
      ST_MUL:  acc_q <= acc_q + pp_sh;
      ST_DIV:  acc_q <= {ge ? diff[W-1:0] : shifted[2*W-1:W], shifted[W-1:1], ge};
      default: ;
    endcase
    if (state_q == ST_FIX && slot_free) begin
      out_value_q <= res;
      out_tag_q   <= op_q.tag;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.result_tag   = out_tag_q;

endmodule

`default_nettype wire

// ----- sv/rv64m_multiply_divide_unit.sv -----
// ---------------------------------------------------------------------------
// rv64m_multiply_divide_unit: RV64 M extension execution unit
// Decode front end with a two-entry queue feeding a multiply/divide back end.
// ---------------------------------------------------------------------------
// The front end takes one request per cycle while its two-entry queue has
// room, so requests are absorbed while earlier ones execute. The back end
// works on one operation at a time: multiplies run operand load, four
// partial products through one shared 32x32 multiplier and sign fix-up;
// divides and remainders get one quotient bit per cycle from the restoring
// divider, and unused action codes skip to fix-up. Results leave in request
// order through a registered output slot that holds while rsp_o is stalled.
`default_nettype none

module rv64m_multiply_divide_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mdu_req_if.sink    req_i,
  mdu_rsp_if.source  rsp_o
);

  mdu_pkg::mdu_op_t op;
  logic             op_valid, op_pop;

  mdu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .op_o       (op),
    .op_valid_o (op_valid),
    .op_pop_i   (op_pop)
  );

  mdu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .op_valid_i (op_valid),
    .op_pop_o   (op_pop),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

// ----- sv/mdu_checker.sv -----
// ---------------------------------------------------------------------------
// mdu_checker: port-level checks for the multiply/divide unit
// Tracks outstanding transfers and checks response handshake rules.
// ---------------------------------------------------------------------------
`default_nettype none

module mdu_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      req_valid_i,
  input wire logic                      req_ready_i,
  input wire logic                      rsp_valid_i,
  input wire logic                      rsp_ready_i,
  input wire logic [mdu_pkg::TAG_W-1:0] rsp_tag_i
);

  logic [2:0] pend_q;
  logic       req_xfer, rsp_xfer;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b00, req_xfer} - {2'b00, rsp_xfer};
    end
  end

  a_no_rsp_after_reset: assert property (@(posedge clk_i) !rst_ni |=> !rsp_valid_i)
    else $error("response valid right after reset");

  a_rsp_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 3'd0)
    else $error("response without outstanding request");

  a_bounded_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd4 |-> !req_ready_i)
    else $error("more requests accepted than the unit can hold");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_tag_i))
    else $error("stalled response dropped or changed");

endmodule

bind rv64m_multiply_divide_unit mdu_checker u_mdu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_tag_i   (rsp_o.result_tag)
);

`default_nettype wire
